FILE: hw/rtl/plcms_pkg.sv
// ----------------------------------------------------------------------------
// plcms_pkg
// Shared constants, register map and types of the pair LCMS momentum core.
// ----------------------------------------------------------------------------
package plcms_pkg;

	// default datapath format
	localparam int MOMENTUM_WIDTH_DEF = 21;
	localparam int FRACTION_BITS_DEF  = 16;

	// front queue depth (power of two)
	localparam int QDEPTH = 2;

	// configuration port
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int NUM_WIN = 6;

	localparam logic [31:0] MASS_SQ_RESET = 32'd83665512;

	// register indexes
	localparam logic [2:0] REG_MASS_SQ  = 3'd0;
	localparam logic [2:0] REG_OUT_MIN  = 3'd1;
	localparam logic [2:0] REG_OUT_MAX  = 3'd2;
	localparam logic [2:0] REG_SIDE_MIN = 3'd3;
	localparam logic [2:0] REG_SIDE_MAX = 3'd4;
	localparam logic [2:0] REG_LONG_MIN = 3'd5;
	localparam logic [2:0] REG_LONG_MAX = 3'd6;

	// window slots, in register order
	localparam int WIN_OUT_MIN  = 0;
	localparam int WIN_OUT_MAX  = 1;
	localparam int WIN_SIDE_MIN = 2;
	localparam int WIN_SIDE_MAX = 3;
	localparam int WIN_LONG_MIN = 4;
	localparam int WIN_LONG_MAX = 5;

	// pair kinds
	localparam logic [1:0] KIND_ORDINARY   = 2'd0;
	localparam logic [1:0] KIND_ROTATED    = 2'd1;
	localparam logic [1:0] KIND_HEMISPHERE = 2'd2;

	// side flags carried along the divider stages
	typedef struct packed {
		logic neg_o;
		logic neg_s;
		logic neg_l;
		logic ovf_o;
		logic ovf_s;
		logic ovf_l;
		logic deg;
		logic mtpos;
	} plcms_flags_t;

endpackage

FILE: hw/rtl/plcms_if.sv
// ----------------------------------------------------------------------------
// plcms_if
// Valid/ready channels of the pair LCMS core: pair requests and results.
// ----------------------------------------------------------------------------
interface plcms_in_if #(parameter int MW = plcms_pkg::MOMENTUM_WIDTH_DEF) ();
	logic              valid;
	logic              ready;
	logic [1:0]        pair_kind;
	logic signed [MW-1:0] first_px;
	logic signed [MW-1:0] first_py;
	logic signed [MW-1:0] first_pz;
	logic signed [MW-1:0] second_px;
	logic signed [MW-1:0] second_py;
	logic signed [MW-1:0] second_pz;

	modport source (output valid, pair_kind, first_px, first_py, first_pz,
		second_px, second_py, second_pz, input ready);
	modport sink (input valid, pair_kind, first_px, first_py, first_pz,
		second_px, second_py, second_pz, output ready);
endinterface

interface plcms_out_if #(parameter int MW = plcms_pkg::MOMENTUM_WIDTH_DEF) ();
	logic              valid;
	logic              ready;
	logic signed [MW:0] q_out;
	logic signed [MW:0] q_side;
	logic signed [MW:0] q_long;
	logic              accepted;
	logic              degenerate;

	modport source (output valid, q_out, q_side, q_long, accepted, degenerate,
		input ready);
	modport sink (input valid, q_out, q_side, q_long, accepted, degenerate,
		output ready);
endinterface

FILE: hw/rtl/plcms_front.sv
// ----------------------------------------------------------------------------
// plcms_front
// Accepts pair requests, applies the pair kind reflection and queues them.
// ----------------------------------------------------------------------------
module plcms_front #(
	parameter int MW = plcms_pkg::MOMENTUM_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	plcms_in_if.sink        pairs,
	output logic            head_vld,
	input  logic            pop,
	output logic signed [MW:0] px1,
	output logic signed [MW:0] py1,
	output logic signed [MW:0] pz1,
	output logic signed [MW:0] px2,
	output logic signed [MW:0] py2,
	output logic signed [MW:0] pz2
);
	import plcms_pkg::*;

	localparam int TW   = MW + 1;
	localparam int ENW  = 6 * TW;
	localparam int PTRW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	logic [ENW-1:0]  buf_q [QDEPTH];
	logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTRW:0]   cnt_q;
	logic            push, do_pop;
	logic signed [TW-1:0] sx, sy, sz;
	logic [ENW-1:0]  entry, head;

	assign pairs.ready = (cnt_q != (PTRW+1)'(QDEPTH));
	assign head_vld    = (cnt_q != '0);
	assign push        = pairs.valid && pairs.ready;
	assign do_pop      = pop && head_vld;

	// reflect the second track by pair kind; unused kind is ordinary
	always_comb begin
		sx = TW'(pairs.second_px);
		sy = TW'(pairs.second_py);
		sz = TW'(pairs.second_pz);
		case (pairs.pair_kind)
			KIND_ROTATED: begin
				sx = -sx;
				sy = -sy;
			end
			KIND_HEMISPHERE: begin
				sx = -sx;
				sy = -sy;
				sz = -sz;
			end
			default: begin
			end
		endcase
	end

	assign entry = {TW'(pairs.first_px), TW'(pairs.first_py), TW'(pairs.first_pz),
		sx, sy, sz};

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= entry;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTRW+1)'(push) - (PTRW+1)'(do_pop);
		end
	end

	assign head = buf_q[rd_ptr_q];
	assign {px1, py1, pz1, px2, py2, pz2} = head;

endmodule

FILE: hw/rtl/plcms_sqrt.sv
// ----------------------------------------------------------------------------
// plcms_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module plcms_sqrt #(
	parameter int INW = 8
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [INW-1:0]         x,
	output logic [(INW+1)/2-1:0]   root
);
	localparam int NE  = INW + INW % 2;
	localparam int LS  = NE / 2;
	localparam int RMW = LS + 2;

	logic [NE-1:0]  x_q   [LS];
	logic [RMW-1:0] rem_q [LS];
	logic [LS-1:0]  rt_q  [LS];

	for (genvar k = 0; k < LS; k++) begin : g_step
		logic [NE-1:0]  xi;
		logic [RMW-1:0] ri, cur, trial;
		logic [LS-1:0]  ti;

		if (k == 0) begin : g_first
			assign xi = NE'(x);
			assign ri = '0;
			assign ti = '0;
		end else begin : g_next
			assign xi = x_q[k-1];
			assign ri = rem_q[k-1];
			assign ti = rt_q[k-1];
		end

		// bring down the next bit pair and try root*4+1
		assign cur   = {ri[LS-1:0], xi[NE-1 -: 2]};
		assign trial = {ti, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				x_q[k] <= xi << 2;
				if (cur >= trial) begin
					rem_q[k] <= cur - trial;
					rt_q[k]  <= {ti[LS-2:0], 1'b1};
				end else begin
					rem_q[k] <= cur;
					rt_q[k]  <= {ti[LS-2:0], 1'b0};
				end
			end
		end
	end

	assign root = rt_q[LS-1];

endmodule

FILE: hw/rtl/plcms_div.sv
// ----------------------------------------------------------------------------
// plcms_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module plcms_div #(
	parameter int NUMW = 16,
	parameter int DENW = 8,
	parameter int QB   = 8
) (
	input  logic            clk,
	input  logic            en,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	output logic [QB-1:0]   quo
);
	// caller guarantees num < den * 2^QB
	localparam int CW = (NUMW > DENW + QB) ? NUMW : DENW + QB;

	logic [CW-1:0]   rem_q [QB];
	logic [DENW-1:0] den_q [QB];
	logic [QB-1:0]   quo_q [QB];

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [CW-1:0]   ri, trial;
		logic [DENW-1:0] di;
		logic [QB-1:0]   qi;

		if (k == 0) begin : g_first
			assign ri = CW'(num);
			assign di = den;
			assign qi = '0;
		end else begin : g_next
			assign ri = rem_q[k-1];
			assign di = den_q[k-1];
			assign qi = quo_q[k-1];
		end

		assign trial = CW'(di) << (QB - 1 - k);

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[k] <= di;
				if (ri >= trial) begin
					rem_q[k] <= ri - trial;
					quo_q[k] <= qi | (QB'(1) << (QB - 1 - k));
				end else begin
					rem_q[k] <= ri;
					quo_q[k] <= qi;
				end
			end
		end
	end

	assign quo = quo_q[QB-1];

endmodule

FILE: hw/rtl/plcms_delay.sv
// ----------------------------------------------------------------------------
// plcms_delay
// Stallable shift line that keeps side data aligned with the long units.
// ----------------------------------------------------------------------------
module plcms_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] sr_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int i = 1; i < D; i++) begin
				sr_q[i] <= sr_q[i-1];
			end
		end
	end

	assign q = sr_q[D-1];

endmodule

FILE: hw/rtl/plcms_back.sv
// ----------------------------------------------------------------------------
// plcms_back
// Energies, boost, transverse rotation, rounded division and window test.
// ----------------------------------------------------------------------------
module plcms_back #(
	parameter int MW = plcms_pkg::MOMENTUM_WIDTH_DEF,
	parameter int FB = plcms_pkg::FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_vld,
	output logic              pop,
	input  logic signed [MW:0] px1,
	input  logic signed [MW:0] py1,
	input  logic signed [MW:0] pz1,
	input  logic signed [MW:0] px2,
	input  logic signed [MW:0] py2,
	input  logic signed [MW:0] pz2,
	input  logic [31:0]       mass_sq,
	input  logic signed [MW:0] win [plcms_pkg::NUM_WIN],
	plcms_out_if.source       results
);
	import plcms_pkg::*;

	// widths
	localparam int TW   = MW + 1;                 // momentum sums and differences
	localparam int QW   = TW;                     // result width
	localparam int SQW  = 2 * MW - 1;             // one squared component
	localparam int MTW  = 2 * FB;                 // mass term
	localparam int ESW  = ((SQW + 2 > MTW) ? SQW + 2 : MTW) + 1;
	localparam int EW   = (ESW + 1) / 2;          // energy
	localparam int M2W  = ((2 * (EW + 1) > 2 * TW - 1) ? 2 * (EW + 1) : 2 * TW - 1) + 1;
	localparam int MRW  = M2W / 2;                // transverse mass
	localparam int PLW  = EW + 2 + TW;            // long numerator products
	localparam int NLW  = EW + TW + 3;            // long numerator
	localparam int NOW  = 2 * TW + 1;             // out / side numerators
	localparam int CWO  = (NOW + 1 > TW + QW) ? NOW + 1 : TW + QW;
	localparam int CWL  = (NLW + 1 > MRW + QW) ? NLW + 1 : MRW + QW;
	localparam int MSH_UP = (2 * FB >= 32) ? 2 * FB - 32 : 0;
	localparam int MSH_DN = (2 * FB >= 32) ? 0 : 32 - 2 * FB;

	// stage positions
	localparam int T_E  = 2 + EW;
	localparam int T_E3 = T_E + 3;
	localparam int T_M  = T_E3 + MRW;
	localparam int T_D  = T_M + 1;
	localparam int T_F  = T_D + QW + 1;

	localparam logic signed [QW-1:0] QMAX_C = {1'b0, {(QW-1){1'b1}}};
	localparam logic signed [QW-1:0] QMIN_C = {1'b1, {(QW-1){1'b0}}};

	logic en;
	logic [T_F-1:0] vld_q;
	logic [MTW-1:0] mterm;

	// stall the whole pipe only when the result register is held
	assign en      = !vld_q[T_F-1] || results.ready;
	assign pop     = en && head_vld;
	assign results.valid = vld_q[T_F-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[T_F-2:0], head_vld};
		end
	end

	assign mterm = MTW'((64'(mass_sq) << MSH_UP) >> MSH_DN);

	// s1: squares, pair sums and differences
	logic signed [2*TW-1:0] m_x1, m_y1, m_z1, m_x2, m_y2, m_z2;
	logic [SQW-1:0] sx1_s1, sy1_s1, sz1_s1, sx2_s1, sy2_s1, sz2_s1;
	logic signed [TW-1:0] tx_s1, ty_s1, tz_s1, dx_s1, dy_s1, dz_s1;
	logic deg_s1;

	assign m_x1 = px1 * px1;
	assign m_y1 = py1 * py1;
	assign m_z1 = pz1 * pz1;
	assign m_x2 = px2 * px2;
	assign m_y2 = py2 * py2;
	assign m_z2 = pz2 * pz2;

	always_ff @(posedge clk) begin
		if (en) begin
			sx1_s1 <= m_x1[SQW-1:0];
			sy1_s1 <= m_y1[SQW-1:0];
			sz1_s1 <= m_z1[SQW-1:0];
			sx2_s1 <= m_x2[SQW-1:0];
			sy2_s1 <= m_y2[SQW-1:0];
			sz2_s1 <= m_z2[SQW-1:0];
			tx_s1  <= px1 + px2;
			ty_s1  <= py1 + py2;
			tz_s1  <= pz1 + pz2;
			dx_s1  <= px1 - px2;
			dy_s1  <= py1 - py2;
			dz_s1  <= pz1 - pz2;
			deg_s1 <= (px1 + px2 == '0) && (py1 + py2 == '0);
		end
	end

	// s2: energy radicands and transverse products
	logic [ESW-1:0] es1_s2, es2_s2;
	logic signed [2*TW-1:0] m_txx, m_tyy, m_po1, m_po2, m_ps1, m_ps2;
	logic [2*TW-2:0] txx_s2, tyy_s2;
	logic signed [2*TW-1:0] po1_s2, po2_s2, ps1_s2, ps2_s2;

	assign m_txx = tx_s1 * tx_s1;
	assign m_tyy = ty_s1 * ty_s1;
	assign m_po1 = dx_s1 * tx_s1;
	assign m_po2 = dy_s1 * ty_s1;
	assign m_ps1 = dy_s1 * tx_s1;
	assign m_ps2 = dx_s1 * ty_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			es1_s2 <= ESW'(sx1_s1) + ESW'(sy1_s1) + ESW'(sz1_s1) + ESW'(mterm);
			es2_s2 <= ESW'(sx2_s1) + ESW'(sy2_s1) + ESW'(sz2_s1) + ESW'(mterm);
			txx_s2 <= m_txx[2*TW-2:0];
			tyy_s2 <= m_tyy[2*TW-2:0];
			po1_s2 <= m_po1;
			po2_s2 <= m_po2;
			ps1_s2 <= m_ps1;
			ps2_s2 <= m_ps2;
		end
	end

	// s3: pair pt radicand and out / side numerators
	logic [2*TW-1:0] ptsum_s3;
	logic signed [NOW-1:0] numo_s3, nums_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ptsum_s3 <= (2*TW)'(txx_s2) + (2*TW)'(tyy_s2);
			numo_s3  <= NOW'(po1_s2) + NOW'(po2_s2);
			nums_s3  <= NOW'(ps1_s2) - NOW'(ps2_s2);
		end
	end

	// energies and pair pt
	logic [EW-1:0] e1, e2;
	logic [TW-1:0] pt;

	plcms_sqrt #(.INW(ESW)) u_sqrt_e1 (.clk(clk), .en(en), .x(es1_s2), .root(e1));
	plcms_sqrt #(.INW(ESW)) u_sqrt_e2 (.clk(clk), .en(en), .x(es2_s2), .root(e2));
	plcms_sqrt #(.INW(2*TW)) u_sqrt_pt (.clk(clk), .en(en), .x(ptsum_s3), .root(pt));

	// s4: total and difference energy, with tz / dz brought alongside
	logic signed [TW-1:0] tz_d, dz_d;
	logic [EW:0] te_s4;
	logic signed [EW:0] de_s4;

	plcms_delay #(.W(2*TW), .D(2 + EW)) u_dly_z (
		.clk(clk), .en(en), .d({tz_s1, dz_s1}), .q({tz_d, dz_d}));

	always_ff @(posedge clk) begin
		if (en) begin
			te_s4 <= (EW+1)'(e1) + (EW+1)'(e2);
			de_s4 <= (EW+1)'(e1) - (EW+1)'(e2);
		end
	end

	// s5: boost products
	logic [2*(EW+1)-1:0] te2_s5;
	logic signed [2*TW-1:0] m_tz2;
	logic [2*TW-2:0] tz2_s5;
	logic signed [PLW-1:0] pl1_s5, pl2_s5;

	assign m_tz2 = tz_d * tz_d;

	always_ff @(posedge clk) begin
		if (en) begin
			te2_s5 <= te_s4 * te_s4;
			tz2_s5 <= m_tz2[2*TW-2:0];
			pl1_s5 <= $signed({1'b0, te_s4}) * dz_d;
			pl2_s5 <= tz_d * de_s4;
		end
	end

	// s6: transverse mass squared and long numerator
	logic signed [M2W-1:0] mt2;
	logic [M2W-2:0] mtin_s6;
	logic signed [NLW-1:0] numl_s6;
	logic mtpos_s6;

	assign mt2 = $signed(M2W'(te2_s5)) - $signed(M2W'(tz2_s5));

	always_ff @(posedge clk) begin
		if (en) begin
			mtpos_s6 <= (mt2 > 0);
			mtin_s6  <= (mt2 > 0) ? mt2[M2W-2:0] : '0;
			numl_s6  <= NLW'(pl1_s5) - NLW'(pl2_s5);
		end
	end

	logic [MRW-1:0] mt;

	plcms_sqrt #(.INW(M2W-1)) u_sqrt_mt (.clk(clk), .en(en), .x(mtin_s6), .root(mt));

	// align everything at the divider setup
	logic signed [NOW-1:0] numo_d, nums_d;
	logic signed [NLW-1:0] numl_d;
	logic [TW-1:0] pt_d;
	logic mtpos_d, deg_d;

	plcms_delay #(.W(2*NOW), .D(T_M - 3)) u_dly_num (
		.clk(clk), .en(en), .d({numo_s3, nums_s3}), .q({numo_d, nums_d}));
	plcms_delay #(.W(TW), .D(T_M - 3 - TW)) u_dly_pt (
		.clk(clk), .en(en), .d(pt), .q(pt_d));
	plcms_delay #(.W(NLW+1), .D(MRW)) u_dly_l (
		.clk(clk), .en(en), .d({numl_s6, mtpos_s6}), .q({numl_d, mtpos_d}));
	plcms_delay #(.W(1), .D(T_M - 1)) u_dly_deg (
		.clk(clk), .en(en), .d(deg_s1), .q(deg_d));

	// s7: magnitudes, rounding offset and overflow detect
	logic [NOW-1:0] abo, abs_;
	logic [NLW-1:0] abl;
	logic [NOW:0]   ao, as_;
	logic [NLW:0]   al;
	logic [NOW:0]   ao_s7, as_s7;
	logic [NLW:0]   al_s7;
	logic [TW-1:0]  pt_s7;
	logic [MRW-1:0] mt_s7;
	plcms_flags_t   fl, fl_s7, fl_d;

	always_comb begin
		abo = numo_d[NOW-1] ? NOW'(-numo_d) : NOW'(numo_d);
		abs_ = nums_d[NOW-1] ? NOW'(-nums_d) : NOW'(nums_d);
		abl = numl_d[NLW-1] ? NLW'(-numl_d) : NLW'(numl_d);
		ao  = (NOW+1)'(abo) + (NOW+1)'(pt_d >> 1);
		as_ = (NOW+1)'(abs_) + (NOW+1)'(pt_d >> 1);
		al  = (NLW+1)'(abl) + (NLW+1)'(mt >> 1);
		fl.neg_o = numo_d[NOW-1];
		fl.neg_s = nums_d[NOW-1];
		fl.neg_l = numl_d[NLW-1];
		fl.ovf_o = CWO'(ao) >= (CWO'(pt_d) << QW);
		fl.ovf_s = CWO'(as_) >= (CWO'(pt_d) << QW);
		fl.ovf_l = CWL'(al) >= (CWL'(mt) << QW);
		fl.deg   = deg_d;
		fl.mtpos = mtpos_d;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ao_s7 <= ao;
			as_s7 <= as_;
			al_s7 <= al;
			pt_s7 <= pt_d;
			mt_s7 <= mt;
			fl_s7 <= fl;
		end
	end

	// rounded quotients
	logic [QW-1:0] qo_u, qs_u, ql_u;

	plcms_div #(.NUMW(NOW+1), .DENW(TW), .QB(QW)) u_div_o (
		.clk(clk), .en(en), .num(ao_s7), .den(pt_s7), .quo(qo_u));
	plcms_div #(.NUMW(NOW+1), .DENW(TW), .QB(QW)) u_div_s (
		.clk(clk), .en(en), .num(as_s7), .den(pt_s7), .quo(qs_u));
	plcms_div #(.NUMW(NLW+1), .DENW(MRW), .QB(QW)) u_div_l (
		.clk(clk), .en(en), .num(al_s7), .den(mt_s7), .quo(ql_u));

	plcms_delay #(.W($bits(plcms_flags_t)), .D(QW)) u_dly_fl (
		.clk(clk), .en(en), .d(fl_s7), .q(fl_d));

	// apply sign and saturate
	function automatic logic signed [QW-1:0] fin_q(input logic [QW-1:0] q,
		input logic ovf, input logic neg);
		logic big;
		if (!neg) begin
			big = ovf || q[QW-1];
			return big ? QMAX_C : $signed(q);
		end else begin
			big = ovf || (q[QW-1] && (q[QW-2:0] != '0));
			return big ? QMIN_C : -$signed(q);
		end
	endfunction

	// s8: final values and window test
	logic signed [QW-1:0] qo, qs, ql;
	logic acc;
	logic signed [QW-1:0] qo_s8, qs_s8, ql_s8;
	logic acc_s8, deg_s8;

	always_comb begin
		qo  = fl_d.deg ? '0 : fin_q(qo_u, fl_d.ovf_o, fl_d.neg_o);
		qs  = fl_d.deg ? '0 : fin_q(qs_u, fl_d.ovf_s, fl_d.neg_s);
		ql  = fl_d.mtpos ? fin_q(ql_u, fl_d.ovf_l, fl_d.neg_l) : '0;
		acc = !fl_d.deg && fl_d.mtpos
			&& (qo >= win[WIN_OUT_MIN]) && (qo <= win[WIN_OUT_MAX])
			&& (qs >= win[WIN_SIDE_MIN]) && (qs <= win[WIN_SIDE_MAX])
			&& (ql >= win[WIN_LONG_MIN]) && (ql <= win[WIN_LONG_MAX]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qo_s8  <= qo;
			qs_s8  <= qs;
			ql_s8  <= ql;
			acc_s8 <= acc;
			deg_s8 <= fl_d.deg;
		end
	end

	assign results.q_out      = qo_s8;
	assign results.q_side     = qs_s8;
	assign results.q_long     = ql_s8;
	assign results.accepted   = acc_s8;
	assign results.degenerate = deg_s8;

endmodule

FILE: hw/rtl/pair_lcms_relative_momentum_core.sv
// Depth: each extra bit of MOMENTUM_WIDTH adds about three stages through the square
//   roots and dividers.
// Throughput: one pair per cycle; the back pipeline stalls as a whole only while
//   the result register is held, and a two-entry queue decouples the front.
// Reset: arst_n clears the queue, the pipeline valid line and the registers
//   (pion mass squared, windows fully open).
// ----------------------------------------------------------------------------
// pair_lcms_relative_momentum_core
// Pair out/side/long relative momentum in the LCMS with window acceptance.
// ----------------------------------------------------------------------------
module pair_lcms_relative_momentum_core #(
	parameter int MOMENTUM_WIDTH = plcms_pkg::MOMENTUM_WIDTH_DEF,
	parameter int FRACTION_BITS  = plcms_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	plcms_in_if.sink                      pairs,
	plcms_out_if.source                   results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [plcms_pkg::ADDR_W-1:0]  paddr,
	input  logic [plcms_pkg::DATA_W-1:0]  pwdata,
	output logic [plcms_pkg::DATA_W-1:0]  prdata,
	output logic                          pready
);
	import plcms_pkg::*;

	localparam int QW = MOMENTUM_WIDTH + 1;

	logic [31:0]          mass_q;
	logic signed [QW-1:0] win_q [NUM_WIN];
	logic [2:0]           idx;
	logic [63:0]          wd64;
	logic                 wr;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wd64   = 64'(pwdata);
	assign wr     = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= MASS_SQ_RESET;
			for (int i = 0; i < NUM_WIN; i++) begin
				win_q[i] <= (i % 2 == 0) ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
			end
		end else if (wr) begin
			case (idx) inside
				REG_MASS_SQ: begin
					mass_q <= pwdata[31:0];
				end
				[REG_OUT_MIN:REG_LONG_MAX]: begin
					win_q[idx - REG_OUT_MIN] <= wd64[QW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// register reads
	always_comb begin
		case (idx) inside
			REG_MASS_SQ:                prdata = DATA_W'(mass_q);
			[REG_OUT_MIN:REG_LONG_MAX]: prdata = DATA_W'(win_q[idx - REG_OUT_MIN]);
			default:                    prdata = '0;
		endcase
	end

	logic                       head_vld, pop;
	logic signed [MOMENTUM_WIDTH:0] px1, py1, pz1, px2, py2, pz2;

	plcms_front #(.MW(MOMENTUM_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .pairs(pairs),
		.head_vld(head_vld), .pop(pop),
		.px1(px1), .py1(py1), .pz1(pz1), .px2(px2), .py2(py2), .pz2(pz2));

	plcms_back #(.MW(MOMENTUM_WIDTH), .FB(FRACTION_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .head_vld(head_vld), .pop(pop),
		.px1(px1), .py1(py1), .pz1(pz1), .px2(px2), .py2(py2), .pz2(pz2),
		.mass_sq(mass_q), .win(win_q), .results(results));

endmodule
